FILE: rtl/core/asri_pkg.sv
// shared types and constants of the adaptive sensor report interval core
`timescale 1ns / 1ps

package asri_pkg;

  localparam int TempW   = 15;
  localparam int HumiW   = 14;
  localparam int PeriodW = 16;
  localparam int IdleW   = 8;
  localparam int TempQW  = 12;  // signed tenths of a degree
  localparam int HumiQW  = 8;   // whole percent
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;
  localparam int InDataW  = 32;
  localparam int OutDataW = 56;

  // reciprocal constants for divide by ten and by one hundred
  localparam logic [15:0] RecipTen     = 16'd52429;
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int          RecipShift   = 19;

  localparam logic [ModeW-1:0] ModeBoot = 2'd0;
  localparam logic [ModeW-1:0] ModeIdle = 2'd1;
  localparam logic [ModeW-1:0] ModeRun  = 2'd2;

  localparam logic [CfgIdxW-1:0] RegTempThr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHumiThr = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinIntv = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxIntv = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStep    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIdleTck = 3'd5;

  localparam logic [TempW-1:0]   TempThrRst = 15'd50;
  localparam logic [HumiW-1:0]   HumiThrRst = 14'd200;
  localparam logic [PeriodW-1:0] MinIntvRst = 16'd60;
  localparam logic [PeriodW-1:0] MaxIntvRst = 16'd300;
  localparam logic [PeriodW-1:0] StepRst    = 16'd60;
  localparam logic [IdleW-1:0]   IdleTckRst = 8'd10;

  typedef struct packed {
    logic signed [TempW-1:0]  temp;
    logic        [HumiW-1:0]  humi;
    logic signed [TempQW-1:0] temp_q;
    logic        [HumiQW-1:0] humi_q;
  } sample_t;

  typedef struct packed {
    logic [TempW-1:0]   temp_thr;
    logic [HumiW-1:0]   humi_thr;
    logic [PeriodW-1:0] min_intv;
    logic [PeriodW-1:0] max_intv;
    logic [PeriodW-1:0] step;
    logic [IdleW-1:0]   idle_ticks;
  } cfg_t;

  typedef struct packed {
    logic               temp_report;
    logic [TempW-1:0]   temp_value;
    logic               humi_report;
    logic [HumiW-1:0]   humi_value;
    logic [PeriodW-1:0] period;
    logic               timer_restart;
    logic [ModeW-1:0]   mode;
  } result_t;

endpackage

FILE: rtl/core/adaptive_sensor_report_interval_core.sv
// top level of the adaptive sensor report interval core
//
// each slave word is one report timer tick carrying a temperature sample
// (signed centidegrees) and a humidity sample (centipercent); every tick
// gives exactly one master word with the report flags, the last reported
// values, the report period in force, a timer restart flag and the mode
// the mode runs boot, idle, running: the boot tick only moves to idle,
// idle ticks report on a change of truncated tenths or whole percent and
// count up to running, running ticks also adapt the report period
// the path has two register stages: an input register that also divides
// the sample down, then the state update that writes the result register;
// the per-tick state loop closes in that one update stage, so a word is
// taken every cycle when the master side flows
// a stalled master word stays put; the input register keeps taking while
// the result register is free or being drained, and tready falls only
// when both stages hold a word
// reset puts the mode in boot, clears reported values, sets the period to
// 60 s and loads the register defaults; the config channel is always ready
// and should be written only while no tick is in flight
`timescale 1ns / 1ps

module adaptive_sensor_report_interval_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side, tdata: temperature[14:0], humidity[28:15], zero pad
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [asri_pkg::InDataW-1:0]    s_tdata_i,
  // master side, tdata: temp_report[0], temp_value[15:1], humi_report[16],
  // humi_value[30:17], period_seconds[46:31], timer_restart[47],
  // mode[49:48], zero pad
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [asri_pkg::OutDataW-1:0]   m_tdata_o,
  // register write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [asri_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [asri_pkg::CfgDatW-1:0]    cfg_data_i
);

  asri_pkg::cfg_t    cfg_q;
  asri_pkg::sample_t sample;
  asri_pkg::result_t result;
  logic              mid_valid;
  logic              mid_ready;

  // register file, written any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_thr   <= asri_pkg::TempThrRst;
      cfg_q.humi_thr   <= asri_pkg::HumiThrRst;
      cfg_q.min_intv   <= asri_pkg::MinIntvRst;
      cfg_q.max_intv   <= asri_pkg::MaxIntvRst;
      cfg_q.step       <= asri_pkg::StepRst;
      cfg_q.idle_ticks <= asri_pkg::IdleTckRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        asri_pkg::RegTempThr: cfg_q.temp_thr   <= cfg_data_i[asri_pkg::TempW-1:0];
        asri_pkg::RegHumiThr: cfg_q.humi_thr   <= cfg_data_i[asri_pkg::HumiW-1:0];
        asri_pkg::RegMinIntv: cfg_q.min_intv   <= cfg_data_i;
        asri_pkg::RegMaxIntv: cfg_q.max_intv   <= cfg_data_i;
        asri_pkg::RegStep:    cfg_q.step       <= cfg_data_i;
        asri_pkg::RegIdleTck: cfg_q.idle_ticks <= cfg_data_i[asri_pkg::IdleW-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // stage one: capture the sample and its truncated quotients
  asri_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .temp_i      ($signed(s_tdata_i[asri_pkg::TempW-1:0])),
    .humi_i      (s_tdata_i[asri_pkg::TempW +: asri_pkg::HumiW]),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .sample_o    (sample)
  );

  // stage two: state update into the result register
  asri_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .sample_i    (sample),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .result_o    (result)
  );

  assign m_tdata_o = {6'd0, result.mode, result.timer_restart, result.period,
                      result.humi_value, result.humi_report, result.temp_value,
                      result.temp_report};

  // a period rewrite only happens on a running tick
  a_pchg_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && result.timer_restart |-> result.mode == asri_pkg::ModeRun)
    else $error("period change reported outside running mode");

  // the boot tick never reports
  a_no_boot_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (result.temp_report || result.humi_report)
      |-> result.mode != asri_pkg::ModeBoot)
    else $error("report flagged while still in boot mode");

  // an empty result register never backs up the slave side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o |-> s_tready_o)
    else $error("slave stalled with an empty result register");

  // a result word appears only after a word left the input register
  a_out_follows_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(mid_valid))
    else $error("result word without a captured sample");

endmodule

FILE: rtl/core/asri_in_stage.sv
// input register with truncated tenths and whole percent of the sample
`timescale 1ns / 1ps

module asri_in_stage (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [asri_pkg::TempW-1:0]     temp_i,
  input  logic        [asri_pkg::HumiW-1:0]     humi_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output asri_pkg::sample_t                     sample_o
);

  logic                                 valid_q, valid_d;
  asri_pkg::sample_t                    sample_q, sample_d;
  logic [asri_pkg::TempW:0]             temp_abs;
  logic [31:0]                          temp_prod;
  logic [26:0]                          humi_prod;
  logic [asri_pkg::TempQW-1:0]          temp_mag;
  logic                                 take;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    // truncation toward zero: divide the magnitude, then restore the sign
    if (temp_i[asri_pkg::TempW-1]) begin
      temp_abs = 16'd0 - {temp_i[asri_pkg::TempW-1], temp_i};
    end else begin
      temp_abs = {1'b0, temp_i};
    end
    temp_prod = temp_abs * asri_pkg::RecipTen;
    humi_prod = humi_i * asri_pkg::RecipHundred;
    temp_mag  = temp_prod[asri_pkg::RecipShift +: asri_pkg::TempQW];
    sample_d.temp   = temp_i;
    sample_d.humi   = humi_i;
    sample_d.temp_q = temp_i[asri_pkg::TempW-1] ? (12'd0 - temp_mag) : temp_mag;
    sample_d.humi_q = humi_prod[asri_pkg::RecipShift +: asri_pkg::HumiQW];
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;

endmodule

FILE: rtl/core/asri_update.sv
// mode, report and period state update with the result register
`timescale 1ns / 1ps

module asri_update (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asri_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  asri_pkg::sample_t sample_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output asri_pkg::result_t result_o
);

  logic [asri_pkg::ModeW-1:0]          mode_q, mode_d;
  logic [asri_pkg::IdleW-1:0]          idle_cnt_q, idle_cnt_d;
  logic signed [asri_pkg::TempW-1:0]   rep_temp_q, rep_temp_d;
  logic [asri_pkg::HumiW-1:0]          rep_humi_q, rep_humi_d;
  logic signed [asri_pkg::TempQW-1:0]  rep_tq_q, rep_tq_d;
  logic [asri_pkg::HumiQW-1:0]         rep_hq_q, rep_hq_d;
  logic [asri_pkg::PeriodW-1:0]        period_q, period_d;
  logic                                out_valid_q, out_valid_d;
  asri_pkg::result_t                   result_q, result_d;

  logic                                step_en;
  logic                                trep, hrep, pchg, hit;
  logic signed [asri_pkg::TempW:0]     dt_s;
  logic signed [asri_pkg::HumiW:0]     dh_s;
  logic [asri_pkg::TempW:0]            dt;
  logic [asri_pkg::HumiW:0]            dh;
  logic [asri_pkg::PeriodW:0]          grown;
  logic [asri_pkg::IdleW-1:0]          idle_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step_en    = in_valid_i && in_ready_o;

  always_comb begin
    mode_d     = mode_q;
    idle_cnt_d = idle_cnt_q;
    rep_temp_d = rep_temp_q;
    rep_humi_d = rep_humi_q;
    rep_tq_d   = rep_tq_q;
    rep_hq_d   = rep_hq_q;
    period_d   = period_q;
    trep       = 1'b0;
    hrep       = 1'b0;
    pchg       = 1'b0;
    hit        = 1'b0;
    idle_inc   = idle_cnt_q + 8'd1;
    grown      = {1'b0, period_q} + {1'b0, cfg_i.step};
    // previous values always equal the reported ones at the start of a tick,
    // so the delta is the jump of a fresh report and zero otherwise
    dt_s = {sample_i.temp[asri_pkg::TempW-1], sample_i.temp}
         - {rep_temp_q[asri_pkg::TempW-1], rep_temp_q};
    dh_s = $signed({1'b0, sample_i.humi}) - $signed({1'b0, rep_humi_q});
    dt   = 16'd0;
    dh   = 15'd0;
    case (mode_q)
      asri_pkg::ModeBoot: begin
        mode_d = asri_pkg::ModeIdle;
      end
      asri_pkg::ModeIdle, asri_pkg::ModeRun: begin
        trep = sample_i.temp_q != rep_tq_q;
        hrep = sample_i.humi_q != rep_hq_q;
        if (trep) begin
          rep_temp_d = sample_i.temp;
          rep_tq_d   = sample_i.temp_q;
          dt         = dt_s[asri_pkg::TempW] ? (16'd0 - dt_s) : dt_s;
        end
        if (hrep) begin
          rep_humi_d = sample_i.humi;
          rep_hq_d   = sample_i.humi_q;
          dh         = dh_s[asri_pkg::HumiW] ? (15'd0 - dh_s) : dh_s;
        end
        if (mode_q == asri_pkg::ModeRun) begin
          hit = (dt >= {1'b0, cfg_i.temp_thr}) || (dh >= {1'b0, cfg_i.humi_thr});
          if (hit) begin
            if (period_q != cfg_i.min_intv) begin
              period_d = cfg_i.min_intv;
              pchg     = 1'b1;
            end
          end else if (period_q < cfg_i.max_intv) begin
            period_d = (grown > {1'b0, cfg_i.max_intv}) ? cfg_i.max_intv
                                                        : grown[asri_pkg::PeriodW-1:0];
            pchg     = 1'b1;
          end
        end else begin
          idle_cnt_d = idle_inc;
          if (idle_inc >= cfg_i.idle_ticks) begin
            idle_cnt_d = 8'd0;
            mode_d     = asri_pkg::ModeRun;
          end
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
    result_d.temp_report   = trep;
    result_d.temp_value    = rep_temp_d;
    result_d.humi_report   = hrep;
    result_d.humi_value    = rep_humi_d;
    result_d.period        = period_d;
    result_d.timer_restart = pchg;
    result_d.mode          = mode_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= asri_pkg::ModeBoot;
      idle_cnt_q  <= '0;
      rep_temp_q  <= '0;
      rep_humi_q  <= '0;
      rep_tq_q    <= '0;
      rep_hq_q    <= '0;
      period_q    <= asri_pkg::MinIntvRst;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step_en) begin
        mode_q     <= mode_d;
        idle_cnt_q <= idle_cnt_d;
        rep_temp_q <= rep_temp_d;
        rep_humi_q <= rep_humi_d;
        rep_tq_q   <= rep_tq_d;
        rep_hq_q   <= rep_hq_d;
        period_q   <= period_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: tb/asri_report_checker.sv
// checker for the report interval core: predicts each result word and compares
`timescale 1ns / 1ps

module asri_report_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [asri_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [asri_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [asri_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [asri_pkg::CfgDatW-1:0]  cfg_data_i,
  output int                            mismatches_o,
  output int                            pending_o
);
  import asri_pkg::*;

  cfg_t                    regs;
  logic [ModeW-1:0]        mode_q;
  logic [IdleW-1:0]        idle_cnt;
  logic signed [TempW-1:0] shown_temp, prior_temp;
  logic [HumiW-1:0]        shown_humi, prior_humi;
  logic [PeriodW-1:0]      period_q;

  result_t expected_reports[$];
  result_t seen_word, due_word;
  int      mismatch_count = 0;
  int      report_index = 0;

  // one timer tick through the mode / report / period logic
  task automatic advance_report_state(input logic signed [TempW-1:0] t,
                                      input logic [HumiW-1:0] h,
                                      output result_t r);
    int t_new, t_old, h_new, h_old, dt, dh, grown;
    r = '0;
    if (mode_q == ModeBoot) begin
      mode_q = ModeIdle;
    end else if (mode_q == ModeIdle || mode_q == ModeRun) begin
      t_new = int'(t);
      t_old = int'(shown_temp);
      h_new = int'(h);
      h_old = int'(shown_humi);
      // truncated tenths / whole percent, toward zero
      if (t_old / 10 != t_new / 10) begin
        shown_temp = t;
        r.temp_report = 1'b1;
      end
      if (h_old / 100 != h_new / 100) begin
        shown_humi = h;
        r.humi_report = 1'b1;
      end
      if (mode_q == ModeRun) begin
        t_new = int'(shown_temp);
        t_old = int'(prior_temp);
        h_new = int'(shown_humi);
        h_old = int'(prior_humi);
        dt = (t_new > t_old) ? t_new - t_old : t_old - t_new;
        dh = (h_new > h_old) ? h_new - h_old : h_old - h_new;
        if (dt >= int'(regs.temp_thr) || dh >= int'(regs.humi_thr)) begin
          if (period_q != regs.min_intv) begin
            period_q = regs.min_intv;
            r.timer_restart = 1'b1;
          end
        end else if (period_q < regs.max_intv) begin
          grown = int'(period_q) + int'(regs.step);
          if (grown > int'(regs.max_intv)) grown = int'(regs.max_intv);
          period_q = grown[PeriodW-1:0];
          r.timer_restart = 1'b1;
        end
      end
      prior_temp = shown_temp;
      prior_humi = shown_humi;
      if (mode_q == ModeIdle) begin
        idle_cnt = idle_cnt + 8'd1;
        if (idle_cnt >= regs.idle_ticks) begin
          idle_cnt = '0;
          mode_q = ModeRun;
        end
      end
    end
    r.temp_value = shown_temp;
    r.humi_value = shown_humi;
    r.period     = period_q;
    r.mode       = mode_q;
  endtask

  task automatic check_field(input string name, input logic [PeriodW-1:0] want,
                             input logic [PeriodW-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("report %0d: %s expected %0d, got %0d", report_index, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.temp_thr   = TempThrRst;
      regs.humi_thr   = HumiThrRst;
      regs.min_intv   = MinIntvRst;
      regs.max_intv   = MaxIntvRst;
      regs.step       = StepRst;
      regs.idle_ticks = IdleTckRst;
      mode_q     = ModeBoot;
      idle_cnt   = '0;
      shown_temp = '0;
      prior_temp = '0;
      shown_humi = '0;
      prior_humi = '0;
      period_q   = MinIntvRst;
      expected_reports.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegTempThr: regs.temp_thr   = cfg_data_i[TempW-1:0];
          RegHumiThr: regs.humi_thr   = cfg_data_i[HumiW-1:0];
          RegMinIntv: regs.min_intv   = cfg_data_i[PeriodW-1:0];
          RegMaxIntv: regs.max_intv   = cfg_data_i[PeriodW-1:0];
          RegStep:    regs.step       = cfg_data_i[PeriodW-1:0];
          RegIdleTck: regs.idle_ticks = cfg_data_i[IdleW-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        seen_word.temp_report   = m_tdata_i[0];
        seen_word.temp_value    = m_tdata_i[15:1];
        seen_word.humi_report   = m_tdata_i[16];
        seen_word.humi_value    = m_tdata_i[30:17];
        seen_word.period        = m_tdata_i[46:31];
        seen_word.timer_restart = m_tdata_i[47];
        seen_word.mode          = m_tdata_i[49:48];
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report %0d: result word with no tick outstanding", report_index);
        end else begin
          due_word = expected_reports.pop_front();
          check_field("temp_report", due_word.temp_report, seen_word.temp_report);
          check_field("temp_value", due_word.temp_value, seen_word.temp_value);
          check_field("humi_report", due_word.humi_report, seen_word.humi_report);
          check_field("humi_value", due_word.humi_value, seen_word.humi_value);
          check_field("period_seconds", due_word.period, seen_word.period);
          check_field("timer_restart", due_word.timer_restart, seen_word.timer_restart);
          check_field("mode", due_word.mode, seen_word.mode);
        end
        report_index++;
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_report_state(s_tdata_i[TempW-1:0], s_tdata_i[TempW+HumiW-1:TempW], due_word);
        expected_reports.push_back(due_word);
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= expected_reports.size();
  end

endmodule

FILE: tb/tb_adaptive_sensor_report_interval_core.sv
// testbench top: feeds sensor ticks and register writes to the report interval core, gives the verdict
`timescale 1ns / 1ps

module tb_adaptive_sensor_report_interval_core;
  import asri_pkg::*;

  // cycles with no word moving on any channel before the run is declared hung
  localparam int QuietLimit    = 2000;
  localparam int PhaseCount    = 12;
  localparam int TicksPerPhase = 120;
  localparam int DirectedTicks = 24;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = RegTempThr;
  logic [CfgDatW-1:0]  cfg_data = '0;

  int report_mismatches;
  int reports_pending;

  int burst_left = 0;
  int walk_temp = 2000;
  int walk_humi = 5000;
  int quiet_cycles = 0;

  // directed ticks, run with the reset register values (idle_ticks 10)
  // tick 0 is the boot tick, its sample is dropped
  // ticks 1..10 are idle: truncation toward zero (9 and -9 stay at tenth 0),
  // the humidity percent edge at 100, both field extremes
  // ticks 11..23 run: growth by one step, threshold exactly met on each
  // field, growth up to the cap, no change at the cap, full-scale swings
  int dir_temp [DirectedTicks] = '{12500, 9, -9, -10, -4000, 12500, 12509, 0, 5, -19,
                                   -11, -11, 30, 80, 80, 80, 80, 80, 80, 80,
                                   80, -4000, 12500, 12500};
  int dir_humi [DirectedTicks] = '{10000, 99, 50, 100, 0, 10000, 10099, 0, 99, 199,
                                   150, 150, 150, 150, 349, 549, 549, 549, 549, 549,
                                   549, 0, 10000, 10000};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  adaptive_sensor_report_interval_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  asri_report_checker report_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (report_mismatches),
    .pending_o    (reports_pending)
  );

  // receiver: each style holds for a random stretch; free flow, coin flip,
  // a fixed low-three-of-eight beat, or heavy back-pressure
  int unsigned rx_style = 0;
  int unsigned rx_left = 0;
  int unsigned rx_beat = 0;

  always @(posedge clk) begin
    rx_beat++;
    if (rx_left == 0) begin
      rx_style = $urandom_range(3);
      rx_left  = $urandom_range(300, 30);
    end else begin
      rx_left--;
    end
    case (rx_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(99) < 55);
      2:       m_tready <= (rx_beat % 8 > 2);
      default: m_tready <= ($urandom_range(99) < 10);
    endcase
  end

  // hang detection: any accepted word on any channel clears the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // one tick word; bursts of random length, with an idle gap between bursts
  // so tvalid never drops and rises in the same step
  task automatic push_tick(input int t, input int h);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = ($urandom_range(3) == 0) ? $urandom_range(40, 8) : $urandom_range(4, 1);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(250, 60) : $urandom_range(20, 1);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, h[HumiW-1:0], t[TempW-1:0]};
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // stop sending and wait until every tick has its result word back
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CfgDatW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int thr_t, input int thr_h, input int min_p,
                          input int max_p, input int step_p, input int idle_n);
    write_reg(RegTempThr, thr_t);
    write_reg(RegHumiThr, thr_h);
    write_reg(RegMinIntv, min_p);
    write_reg(RegMaxIntv, max_p);
    write_reg(RegStep, step_p);
    write_reg(RegIdleTck, idle_n);
  endtask

  // mostly a drifting sample (small drift keeps the period growing, larger
  // drift trips thresholds), with full-range jumps and field extremes
  task automatic wander_ticks(input int count);
    int pick, span_t, span_h;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        walk_temp = int'($urandom_range(16500)) - 4000;
        walk_humi = $urandom_range(10000);
      end else if (pick < 12) begin
        walk_temp = $urandom_range(1) ? 12500 : -4000;
        walk_humi = $urandom_range(1) ? 10000 : 0;
      end else begin
        span_t = (pick < 40) ? 90 : 9;
        span_h = (pick < 40) ? 350 : 40;
        walk_temp += int'($urandom_range(2 * span_t)) - span_t;
        walk_humi += int'($urandom_range(2 * span_h)) - span_h;
        if (walk_temp < -4000) walk_temp = -4000;
        if (walk_temp > 12500) walk_temp = 12500;
        if (walk_humi < 0) walk_humi = 0;
        if (walk_humi > 10000) walk_humi = 10000;
      end
      push_tick(walk_temp, walk_humi);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirectedTicks; i++) push_tick(dir_temp[i], dir_humi[i]);
    settle();

    // the core is in running mode from here on, so idle_ticks writes only
    // land in the register
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        // every tick hits a zero threshold, period pinned at the minimum
        0: set_regs(0, 0, 1, 1, 0, 0);
        // top of every range
        1: set_regs(16500, 10000, 65535, 65535, 65535, 255);
        // reset to one second, then a huge step saturates at the cap
        2: set_regs(400, 1500, 1, 65535, 65535, 1);
        // cap dropped under a period left high, and minimum above the cap
        3: set_regs(80, 300, 200, 100, 7, 10);
        // zero step still restarts the timer below the cap
        4: set_regs(60, 250, 30, 240, 0, 200);
        default: begin
          set_regs(($urandom_range(9) == 0) ? 0 : $urandom_range(150),
                   ($urandom_range(9) == 0) ? 0 : $urandom_range(600),
                   $urandom_range(120, 1), $urandom_range(2000, 1),
                   $urandom_range(200), $urandom_range(255, 1));
        end
      endcase
      wander_ticks(TicksPerPhase);
      settle();
    end

    repeat (8) @(posedge clk);
    if (report_mismatches == 0 && reports_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
